// ===== design/sct_pkg.sv =====
// shared types for the sparse coo transpose sorter
`default_nettype none

package sct_pkg;

  typedef struct packed {
    logic [15:0] col;
    logic [15:0] row;
    logic [31:0] value;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t ent;
  } slot_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

endpackage

`default_nettype wire

// ===== design/sct_cell.sv =====
// one insertion cell of the sorting chain
`default_nettype none

module sct_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sct_pkg::cell_ctrl_t ctrl_i,
  input  wire sct_pkg::entry_t     new_i,
  input  wire sct_pkg::slot_t      prev_i,
  input  wire logic                prev_gt_i,
  input  wire sct_pkg::slot_t      next_i,
  output sct_pkg::slot_t           slot_o,
  output logic                     gt_o
);

  logic            valid_q, valid_d;
  sct_pkg::entry_t ent_q, ent_d;

  // empty cells rank above any key, equal keys stay ahead of the new entry
  assign gt_o = !valid_q || ({ent_q.row, ent_q.col} > {new_i.row, new_i.col});

  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    if (ctrl_i.ins) begin
      if (gt_o) begin
        if (prev_gt_i) begin
          valid_d = prev_i.valid;
          ent_d   = prev_i.ent;
        end else begin
          valid_d = 1'b1;
          ent_d   = new_i;
        end
      end
    end else if (ctrl_i.pop) begin
      valid_d = next_i.valid;
      ent_d   = next_i.ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign slot_o = '{valid: valid_q, ent: ent_q};

endmodule

`default_nettype wire

// ===== design/sparse_coo_transpose_sort.sv =====
// top level: loads coo entries, transposes them and emits them sorted by position
// loading takes one request per cycle into a chain of MAX_ENTRIES insertion cells
// the first result is offered in the cycle after the request marked last is accepted
// results then leave the head of the chain at one per cycle while m_axis_tready is high
// no request is taken while a sorted set is being emitted
// reset empties every cell and clears the entry count and the overflow flag
`default_nettype none

module sparse_coo_transpose_sort #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // value, row_in, col_in
  input  wire logic        s_axis_tlast,  // last_in
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // value_out, row_out, col_out
  output logic             m_axis_tlast,  // last_out
  output logic             m_axis_tuser   // overflow
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  sct_pkg::state_e    state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               dropped_q, dropped_d;
  logic               in_acc, out_acc, full;
  sct_pkg::entry_t    new_ent;
  sct_pkg::cell_ctrl_t ctrl;

  sct_pkg::slot_t     slots [MAX_ENTRIES];
  logic               gts   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_vec;

  assign full   = (count_q == CNT_W'(MAX_ENTRIES));
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // transpose on entry: new row is the loaded column
  assign new_ent.value = s_axis_tdata[31:0];
  assign new_ent.row   = s_axis_tdata[63:48];
  assign new_ent.col   = s_axis_tdata[47:32];

  assign ctrl.ins = in_acc && !full;
  assign ctrl.pop = out_acc;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    sct_pkg::slot_t prev_s, next_s;
    logic           prev_gt;
    if (i == 0) begin : g_head
      assign prev_s  = '0;
      assign prev_gt = 1'b0;
    end else begin : g_mid
      assign prev_s  = slots[i-1];
      assign prev_gt = gts[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign next_s = '0;
    end else begin : g_body
      assign next_s = slots[i+1];
    end
    sct_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .new_i     (new_ent),
      .prev_i    (prev_s),
      .prev_gt_i (prev_gt),
      .next_i    (next_s),
      .slot_o    (slots[i]),
      .gt_o      (gts[i])
    );
    assign valid_vec[i] = slots[i].valid;
  end

  assign s_axis_tready = (state_q == sct_pkg::ST_LOAD);
  assign m_axis_tvalid = (state_q == sct_pkg::ST_DRAIN) && slots[0].valid;
  assign m_axis_tdata  = slots[0].ent;
  assign m_axis_tlast  = !slots[1].valid;
  assign m_axis_tuser  = dropped_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    case (state_q)
      sct_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            dropped_d = 1'b1;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
          if (s_axis_tlast) begin
            state_d = sct_pkg::ST_DRAIN;
          end
        end
      end
      sct_pkg::ST_DRAIN: begin
        if (out_acc && m_axis_tlast) begin
          state_d   = sct_pkg::ST_LOAD;
          count_d   = '0;
          dropped_d = 1'b0;
        end
      end
      default: begin
        state_d = sct_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sct_pkg::ST_LOAD;
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
    end
  end

  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sct_pkg::ST_LOAD) |-> ($countones(valid_vec) == int'(count_q)))
    else $error("entry count differs from occupied cells");

  a_drain_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sct_pkg::ST_DRAIN) |-> slots[0].valid)
    else $error("head cell empty while emitting");

  a_close_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> (state_q == sct_pkg::ST_DRAIN))
    else $error("last request did not start emission");

  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && m_axis_tlast) |=> (count_q == '0 && !dropped_q && valid_vec == '0))
    else $error("chain not empty after final result");

endmodule

`default_nettype wire

// ===== tb/sparse_coo_transpose_sort_tb.sv =====
// testbench for sparse_coo_transpose_sort: directed and random coo sets checked against a sorted transpose
module sparse_coo_transpose_sort_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ENTRIES  = 64;
  localparam int IDLE_LIMIT   = 5000;
  localparam int RANDOM_ITEMS = 430;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    sct_pkg::entry_t ent;
    bit              last;
    bit              ovf;
  } emitted_t;

  class coo_transpose_predictor;
    sct_pkg::entry_t transposed[MAX_ENTRIES];
    int unsigned     n_loaded;
    bit              dropped;
    emitted_t        pending_sorted[$];
    int unsigned     mismatches;

    function new();
      n_loaded   = 0;
      dropped    = 1'b0;
      mismatches = 0;
    endfunction

    // takes one accepted request, entry given in load coordinates
    function void load_entry(sct_pkg::entry_t e, bit last);
      sct_pkg::entry_t sorted[MAX_ENTRIES];
      sct_pkg::entry_t t;
      emitted_t        x;
      int              j;
      if (n_loaded < MAX_ENTRIES) begin
        transposed[n_loaded] = '{col: e.row, row: e.col, value: e.value};
        n_loaded++;
      end else begin
        dropped = 1'b1;
      end
      if (!last) return;
      // stable insertion sort on new row, then new column
      for (int i = 0; i < n_loaded; i++) begin
        t = transposed[i];
        j = i;
        while (j > 0 && {sorted[j-1].row, sorted[j-1].col} > {t.row, t.col}) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = t;
      end
      for (int i = 0; i < n_loaded; i++) begin
        x.ent  = sorted[i];
        x.last = (i == n_loaded - 1);
        x.ovf  = dropped;
        pending_sorted.push_back(x);
      end
      n_loaded = 0;
      dropped  = 1'b0;
    endfunction

    function void check_emitted(sct_pkg::entry_t got, bit got_last, bit got_ovf);
      emitted_t want;
      if (pending_sorted.size() == 0) begin
        $display("%0t: result with none expected: value %h row %h col %h last %b ovf %b",
                 $time, got.value, got.row, got.col, got_last, got_ovf);
        mismatches++;
        return;
      end
      want = pending_sorted.pop_front();
      if (got.value !== want.ent.value) begin
        $display("%0t: value expected %h actual %h", $time, want.ent.value, got.value);
        mismatches++;
      end
      if (got.row !== want.ent.row) begin
        $display("%0t: row expected %h actual %h", $time, want.ent.row, got.row);
        mismatches++;
      end
      if (got.col !== want.ent.col) begin
        $display("%0t: col expected %h actual %h", $time, want.ent.col, got.col);
        mismatches++;
      end
      if (got_last !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, got_last);
        mismatches++;
      end
      if (got_ovf !== want.ovf) begin
        $display("%0t: overflow expected %b actual %b", $time, want.ovf, got_ovf);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  bit          sender_gaps     = 1'b0;
  bit          receiver_stalls = 1'b0;
  bit          hold_armed      = 1'b0;
  int          items_sent      = 0;
  int          quiet_cycles    = 0;

  coo_transpose_predictor coo = new();

  sparse_coo_transpose_sort #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tlast (s_tlast),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tlast (m_tlast),
    .m_axis_tuser (m_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic offer_entry(input logic [31:0] value, input logic [15:0] r_in,
                             input logic [15:0] c_in, input bit last);
    int gap;
    gap = pick_gap(sender_gaps);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tdata  = {c_in, r_in, value};
    s_tlast  = last;
    s_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_tready);
    coo.load_entry('{col: c_in, row: r_in, value: value}, last);
    items_sent++;
    @(negedge clk_i);
  endtask

  // narrow coordinates make equal positions common
  task automatic offer_set(input int size, input bit narrow);
    logic [15:0] r_in;
    logic [15:0] c_in;
    for (int i = 0; i < size; i++) begin
      r_in = narrow ? 16'($urandom_range(3)) : 16'($urandom_range(65535));
      c_in = narrow ? 16'($urandom_range(3)) : 16'($urandom_range(65535));
      offer_entry($urandom, r_in, c_in, i == size - 1);
    end
  endtask

  function automatic int pick_set_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(16, 1);
    if (r < 85) return $urandom_range(MAX_ENTRIES - 1, 17);
    if (r < 90) return MAX_ENTRIES;
    return $urandom_range(MAX_ENTRIES + 8, MAX_ENTRIES + 1);
  endfunction

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // single entries at the corners of every field
    offer_entry(32'h8000_0000, 16'h0000, 16'hFFFF, 1'b1);
    offer_entry(32'h7FFF_FFFF, 16'hFFFF, 16'h0000, 1'b1);
    // equal positions keep load order
    offer_entry(32'h0000_0000, 16'd5, 16'd5, 1'b0);
    offer_entry(32'hFFFF_FFFF, 16'd5, 16'd5, 1'b0);
    offer_entry(32'h0000_0003, 16'd0, 16'd0, 1'b0);
    offer_entry(32'h0000_0004, 16'd2, 16'd1, 1'b0);
    offer_entry(32'h0000_0005, 16'd1, 16'd2, 1'b0);
    offer_entry(32'h0000_0006, 16'd5, 16'd5, 1'b1);
    // reverse order
    for (int i = 4; i >= 0; i--) begin
      offer_entry(32'(i * 32'h1111_1111), 16'(i * 16'h3333), 16'(i * 16'h3333), i == 0);
    end

    items_sent = 0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    offer_set(MAX_ENTRIES, 1'b0);
    // long receiver hold while the next set is already offered
    hold_armed = 1'b1;
    offer_set(MAX_ENTRIES + 3, 1'b1);
    while (items_sent < RANDOM_ITEMS) begin
      sender_gaps     = ($urandom_range(3) != 0);
      receiver_stalls = ($urandom_range(3) != 0);
      offer_set(pick_set_size(), $urandom_range(1));
    end
    s_tvalid = 1'b0;
    s_tlast  = 1'b0;

    while (coo.pending_sorted.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (coo.mismatches == 0 && coo.pending_sorted.size() == 0) begin
      $display("[sparse_coo_transpose_sort] OK");
    end else begin
      $display("[sparse_coo_transpose_sort] ERROR");
    end
    $finish;
  end

  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_armed && m_tvalid) begin
        hold_armed = 1'b0;
        m_tready   = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      stall = pick_gap(receiver_stalls);
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      coo.check_emitted(m_tdata, m_tlast, m_tuser);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("[sparse_coo_transpose_sort] ERROR");
        $finish;
      end
    end
  end

endmodule
